[hdl/mbps_pkg.sv]
// shared types and constants for the masked byte pattern search
package mbps_pkg;

  localparam int MAX_PATTERN_BYTES_DEF = 16;
  localparam int OFFSET_BITS_DEF       = 32;
  localparam int SIG_BYTES             = 16;
  localparam int CFG_INDEX_W           = 8;
  localparam int CFG_DATA_W            = 64;
  localparam int CARE_W                = 16;
  localparam int LENGTH_W              = 5;
  localparam int OFFSET_OUT_W          = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK      = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = CFG_INDEX_W'(3);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic                    found;
    logic [OFFSET_OUT_W-1:0] match_offset;
  } out_item_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] pattern_low;
    logic [CFG_DATA_W-1:0] pattern_high;
    logic [CARE_W-1:0]     care_mask;
    logic [LENGTH_W-1:0]   pattern_length;
  } cfg_t;

endpackage

[hdl/masked_byte_pattern_search.sv]
// top level of the masked byte pattern search
// result: an accepted byte waits in the input register; a match or the last byte of a
// range puts a result into the result register, which holds it while result_stall is high
// throughput: one byte per cycle while the output is not stalled, set by the combinational window compare
// between the input register and the result register
// reset: synchronous, clears both valid flags, the offset count, the found flag and
// the config to pattern 0, care mask 0, length 1
module masked_byte_pattern_search import mbps_pkg::*; #(
  parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
  parameter int OFFSET_BITS       = OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  in_item_t               item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output out_item_t              result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t      cfg;
  in_item_t  in_reg;
  logic      in_reg_valid;
  logic      out_free;
  logic      advance;
  logic      emit;
  out_item_t core_res;

  mbps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mbps_scan_core #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .OFFSET_BITS       (OFFSET_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_reg),
    .cfg     (cfg),
    .emit    (emit),
    .res     (core_res)
  );

  assign out_free   = !result_valid || !result_stall;
  assign advance    = in_reg_valid && out_free;
  assign item_stall = in_reg_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_reg <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= core_res;
    end
  end

endmodule

[hdl/mbps_cfg_regs.sv]
// configuration register file for the pattern search
module mbps_cfg_regs import mbps_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  logic wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_low    <= '0;
      cfg.pattern_high   <= '0;
      cfg.care_mask      <= '0;
      cfg.pattern_length <= LENGTH_W'(1);
    end else if (wr) begin
      case (cfg_index)
        REG_PATTERN_LOW:    cfg.pattern_low    <= cfg_data;
        REG_PATTERN_HIGH:   cfg.pattern_high   <= cfg_data;
        REG_CARE_MASK:      cfg.care_mask      <= cfg_data[CARE_W-1:0];
        REG_PATTERN_LENGTH: cfg.pattern_length <= cfg_data[LENGTH_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[hdl/mbps_scan_core.sv]
// byte window, offset counter and masked window compare
module mbps_scan_core import mbps_pkg::*; #(
  parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
  parameter int OFFSET_BITS       = OFFSET_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output logic      emit,
  output out_item_t res
);

  localparam int LEN_W   = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int IDX_W   = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam int EXT_W   = (OFFSET_BITS > OFFSET_OUT_W) ? OFFSET_BITS : OFFSET_OUT_W;
  localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

  logic [7:0]             window [MAX_PATTERN_BYTES];
  logic [7:0]             win_next [MAX_PATTERN_BYTES];
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic [OFFSET_BITS-1:0] bytes_seen_next;
  logic                   already_found;
  logic [LEN_W-1:0]       len;
  logic [8*SIG_BYTES-1:0] sig;
  logic [MAX_PATTERN_BYTES-1:0] miss;
  logic                   match;
  logic [OFFSET_BITS-1:0] diff;
  logic [EXT_W-1:0]       diff_ext;

  assign sig = {cfg.pattern_high, cfg.pattern_low};

  always_comb begin
    if (cfg.pattern_length == '0) begin
      len = LEN_W'(1);
    end else if (32'(cfg.pattern_length) > 32'(MAX_PATTERN_BYTES)) begin
      len = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      len = LEN_W'(cfg.pattern_length);
    end
  end

  // entry 0 is the newest byte
  always_comb begin
    win_next[0] = item.data_byte;
    for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
      win_next[j] = window[j-1];
    end
  end

  assign bytes_seen_next = (bytes_seen == COUNT_MAX) ? bytes_seen : bytes_seen + 1'b1;

  always_comb begin
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      logic [IDX_W-1:0] pos;
      pos = IDX_W'(len - LEN_W'(1) - LEN_W'(i));
      miss[i] = (LEN_W'(i) < len) && cfg.care_mask[i] && (win_next[pos] != sig[8*i +: 8]);
    end
  end

  assign match    = (bytes_seen_next >= OFFSET_BITS'(len)) && (miss == '0);
  assign diff     = bytes_seen_next - OFFSET_BITS'(len);
  assign diff_ext = EXT_W'(diff);

  assign emit             = advance && !already_found && (match || item.last_byte);
  assign res.found        = match;
  assign res.match_offset = match ? diff_ext[OFFSET_OUT_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (advance && !already_found) begin
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
        window[j] <= win_next[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen    <= '0;
      already_found <= 1'b0;
    end else if (advance) begin
      if (item.last_byte) begin
        bytes_seen    <= '0;
        already_found <= 1'b0;
      end else if (!already_found) begin
        bytes_seen    <= bytes_seen_next;
        already_found <= match;
      end
    end
  end

endmodule

[hdl/mbps_checker.sv]
// port-level checks for the masked byte pattern search
module mbps_checker import mbps_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      result_valid,
  input logic      result_stall,
  input out_item_t result,
  input logic      cfg_ready
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result item changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.found |-> result.match_offset == '0)
    else $error("not-found item carries an offset");

  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind masked_byte_pattern_search mbps_checker u_mbps_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result),
  .cfg_ready    (cfg_ready)
);

[tb/masked_byte_pattern_search_tb.sv]
// testbench for the masked byte pattern search: directed and random byte ranges against a signature predictor
`timescale 1ns / 100ps

module masked_byte_pattern_search_tb;
  import mbps_pkg::*;

  localparam int SCAN_COUNT_BITS = OFFSET_BITS_DEF;
  localparam int SETTLE_CYCLES   = 4;
  localparam int HOLD_CYCLES     = 80;
  localparam int TARGET_BYTES    = 1250;
  localparam int QUIET_BYTES     = 1100;

  typedef enum {RANGE_NOISE, RANGE_PLANTED, RANGE_BROKEN, RANGE_TAIL} range_shape_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   item_valid = 1'b0;
  logic                   item_stall;
  in_item_t               item = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  out_item_t              result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // signature registers and per-range scan state of the predictor
  logic [CFG_DATA_W-1:0]      sig_low = '0;
  logic [CFG_DATA_W-1:0]      sig_high = '0;
  logic [CARE_W-1:0]          care_bits = '0;
  logic [LENGTH_W-1:0]        sig_len_reg = LENGTH_W'(1);
  logic [7:0]                 recent [SIG_BYTES] = '{default: '0};
  logic [SCAN_COUNT_BITS-1:0] seen_count = '0;
  bit                         range_found = 1'b0;

  in_item_t    pending_bytes [$];
  out_item_t   awaiting_reports [$];
  int unsigned errors = 0;
  int unsigned fed = 0;
  int unsigned idle_odds = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  bit          long_hold_pending = 1'b0;

  masked_byte_pattern_search #(
    .OFFSET_BITS(SCAN_COUNT_BITS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned sig_len();
    if (sig_len_reg == 0) return 1;
    if (sig_len_reg > MAX_PATTERN_BYTES_DEF) return MAX_PATTERN_BYTES_DEF;
    return sig_len_reg;
  endfunction

  function automatic logic [7:0] sig_at(input int unsigned k);
    logic [2*CFG_DATA_W-1:0] both;
    both = {sig_high, sig_low};
    return both[8*k +: 8];
  endfunction

  function automatic void advance_scan(input in_item_t it);
    int unsigned len;
    bit          hit;
    out_item_t   rep;
    len = sig_len();
    if (!range_found) begin
      for (int k = SIG_BYTES - 1; k > 0; k--) recent[k] = recent[k-1];
      recent[0] = it.data_byte;
      if (!(&seen_count)) seen_count++;
      hit = (seen_count >= len);
      for (int k = 0; k < len; k++) begin
        if (care_bits[k] && recent[len-1-k] != sig_at(k)) hit = 1'b0;
      end
      if (hit) begin
        range_found = 1'b1;
        rep.found = 1'b1;
        rep.match_offset = OFFSET_OUT_W'(seen_count) - len;
        awaiting_reports.push_back(rep);
      end else if (it.last_byte) begin
        rep = '0;
        awaiting_reports.push_back(rep);
      end
    end
    if (it.last_byte) begin
      recent = '{default: '0};
      seen_count = '0;
      range_found = 1'b0;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (item_valid && !item_stall) advance_scan(item);
      if (!item_valid || !item_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          item <= pending_bytes.pop_front();
          item_valid <= 1'b1;
          if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds)
            send_gap = $urandom_range(1, 8);
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (long_hold_pending) begin
        stall_left = HOLD_CYCLES;
        long_hold_pending = 1'b0;
      end else if (stall_left == 0 && idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
        stall_left = $urandom_range(1, 8);
      end
      if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && result_valid && !result_stall) begin
      if (awaiting_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got found=%0b offset=%0d",
                 $time, result.found, result.match_offset);
      end else begin
        want = awaiting_reports.pop_front();
        if (result.found !== want.found) begin
          errors++;
          $display("%0t: found mismatch: expected %0b, got %0b",
                   $time, want.found, result.found);
        end
        if (result.match_offset !== want.match_offset) begin
          errors++;
          $display("%0t: match_offset mismatch: expected %0d, got %0d",
                   $time, want.match_offset, result.match_offset);
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PATTERN_LOW:    sig_low = val;
      REG_PATTERN_HIGH:   sig_high = val;
      REG_CARE_MASK:      care_bits = val[CARE_W-1:0];
      REG_PATTERN_LENGTH: sig_len_reg = val[LENGTH_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_signature(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                                input logic [CARE_W-1:0] care, input logic [LENGTH_W-1:0] len);
    @(posedge clk);
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_CARE_MASK, {$urandom, 16'($urandom), care});
    write_reg(REG_PATTERN_LENGTH, {$urandom, 27'($urandom), len});
    // unknown index, must be ignored
    write_reg(CFG_INDEX_W'($urandom_range(REG_PATTERN_LENGTH + 1, {CFG_INDEX_W{1'b1}})),
              {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_byte(input logic [7:0] d, input bit last);
    in_item_t it;
    it.data_byte = d;
    it.last_byte = last;
    pending_bytes.push_back(it);
  endtask

  task automatic queue_range(input int unsigned n, input range_shape_t shape);
    logic [7:0]  range_bytes [];
    int unsigned cared [$];
    int unsigned len, pos;
    range_bytes = new[n];
    for (int i = 0; i < n; i++) range_bytes[i] = 8'($urandom);
    len = sig_len();
    if (shape != RANGE_NOISE && n >= len) begin
      pos = (shape == RANGE_TAIL) ? n - len : $urandom_range(0, n - len);
      for (int k = 0; k < len; k++) begin
        if (care_bits[k]) begin
          range_bytes[pos+k] = sig_at(k);
          cared.push_back(k);
        end
      end
      if (shape == RANGE_BROKEN && cared.size() > 0)
        range_bytes[pos + cared[$urandom_range(0, cared.size() - 1)]] ^= 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < n; i++) queue_byte(range_bytes[i], i == n - 1);
    fed += n;
  endtask

  task automatic drain_scan();
    do @(negedge clk); while (pending_bytes.size() != 0 || item_valid || awaiting_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int unsigned       phase;
    int unsigned       n;
    int unsigned       stop_at;
    logic [CARE_W-1:0] care;
    logic [LENGTH_W-1:0] len;
    range_shape_t      shape;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // four byte signature 00 ff ?? 80
    load_signature(64'h0000_0000_805A_FF00, '0, 16'h000B, LENGTH_W'(4));
    // range shorter than the signature
    queue_byte(8'h00, 0); queue_byte(8'hFF, 0); queue_byte(8'h5A, 1);
    // match on the last byte
    queue_byte(8'h00, 0); queue_byte(8'hFF, 0); queue_byte(8'h77, 0); queue_byte(8'h80, 1);
    // bytes after a match are ignored
    queue_byte(8'h11, 0); queue_byte(8'h00, 0); queue_byte(8'hFF, 0); queue_byte(8'h12, 0);
    queue_byte(8'h80, 0); queue_byte(8'h00, 0); queue_byte(8'h80, 0); queue_byte(8'hFF, 1);
    // no match
    queue_byte(8'hFF, 0); queue_byte(8'h00, 0); queue_byte(8'h5A, 0); queue_byte(8'h80, 1);
    drain_scan();
    // zero length acts as one
    load_signature(64'h0000_0000_0000_00FF, '0, 16'hFFFF, '0);
    queue_byte(8'hFF, 1); queue_byte(8'h00, 1);
    drain_scan();

    phase = 0;
    while (fed < TARGET_BYTES) begin
      stop_at = (fed < QUIET_BYTES) ? QUIET_BYTES : TARGET_BYTES;
      if (fed >= QUIET_BYTES) begin
        idle_odds = 0;
      end else begin
        case ($urandom_range(0, 3))
          0: idle_odds = 0;
          1: idle_odds = 8;
          default: idle_odds = 25;
        endcase
      end
      care = 16'($urandom);
      case (phase % 6)
        0: begin care = 16'hFFFF; len = LENGTH_W'(MAX_PATTERN_BYTES_DEF); end
        1: begin care = '0; len = LENGTH_W'(1); end
        2: len = LENGTH_W'($urandom_range(MAX_PATTERN_BYTES_DEF + 1, 31));
        3: len = '0;
        default: len = LENGTH_W'($urandom_range(1, 8));
      endcase
      if (phase == 1) begin
        idle_odds = 0;
        long_hold_pending = 1'b1;
      end
      load_signature({$urandom, $urandom}, {$urandom, $urandom}, care, len);
      if (phase == 1) begin
        repeat (40) queue_range($urandom_range(1, 3), RANGE_PLANTED);
      end else begin
        repeat ($urandom_range(6, 14)) begin
          if (fed < stop_at) begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
            case ($urandom_range(0, 19))
              0, 1, 2:    shape = RANGE_BROKEN;
              3, 4, 5:    shape = RANGE_NOISE;
              default:    shape = RANGE_PLANTED;
            endcase
            queue_range(n, shape);
          end
        end
        // long ranges push the offset counter past one byte
        if (phase % 6 == 0 && fed + 300 <= stop_at)
          queue_range($urandom_range(260, 300), (phase % 12 == 0) ? RANGE_TAIL : RANGE_NOISE);
      end
      drain_scan();
      phase++;
    end

    if (errors == 0) begin
      $display("masked_byte_pattern_search_tb: PASS");
    end else begin
      $display("masked_byte_pattern_search_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("masked_byte_pattern_search_tb: FAIL");
    $finish;
  end

endmodule

[sim.f]
hdl/mbps_pkg.sv
hdl/mbps_cfg_regs.sv
hdl/mbps_scan_core.sv
hdl/masked_byte_pattern_search.sv
hdl/mbps_checker.sv
tb/masked_byte_pattern_search_tb.sv
